### sv/nms_pkg.sv
package nms_pkg;

    localparam int DIM_BITS = 11;
    localparam int CMP_BITS = DIM_BITS + 3;
    localparam int MIN_DIM = 3;
    localparam int REG_IDX_BITS = 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET = 11'd640;
    localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = 11'd480;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } nms_reg_t;

    typedef enum logic [1:0] {
        DIR_0   = 2'd0,
        DIR_45  = 2'd1,
        DIR_90  = 2'd2,
        DIR_135 = 2'd3
    } nms_dir_t;

    typedef struct packed {
        logic emit;
        logic last_col;
        logic last_row;
    } nms_flags_t;

endpackage

### sv/nms_ram.sv
module nms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/nms_queue.sv
module nms_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn) !(push && full))
        else $error("queue overflow");
    assert property (@(posedge aclk) disable iff (!aresetn) !(pop && empty))
        else $error("queue underflow");
`endif

endmodule

### sv/nms_front.sv
module nms_front
    import nms_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAG_BITS = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [REG_IDX_BITS-1:0] cfg_index,
    input  logic [DIM_BITS-1:0]     cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [MAG_BITS-1:0]     s_magnitude,
    input  logic [1:0]              s_direction,
    output logic                    q_push,
    input  logic                    q_full,
    output logic [MAG_BITS-1:0]     q_up_mag,
    output logic [MAG_BITS-1:0]     q_mid_mag,
    output logic [1:0]              q_mid_dir,
    output logic [MAG_BITS-1:0]     q_mag,
    output nms_flags_t              q_flags
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int RAM_W = 2 * MAG_BITS + 2;

    logic [DIM_BITS-1:0] frame_width_reg, frame_height_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [DIM_BITS-1:0] row_reg, row_next;

    logic                s1_valid_reg, s1_valid_next;
    logic [MAG_BITS-1:0] s1_mag_reg;
    logic [1:0]          s1_dir_reg;
    logic [COL_W-1:0]    s1_col_reg;
    nms_flags_t          s1_flags_reg;

    logic                accept, advance;
    logic [CMP_BITS-1:0] w_eff, w_last, col_ext;
    logic [DIM_BITS-1:0] h_eff, h_last;
    logic                last_col, last_row;
    nms_flags_t          flags;
    logic [RAM_W-1:0]    rd_data, wr_data;

    assign advance = s1_valid_reg && !q_full;
    assign s_ready = !s1_valid_reg || advance;
    assign accept = s_valid && s_ready;

    always_comb begin
        w_eff = CMP_BITS'(frame_width_reg);
        if (w_eff < CMP_BITS'(MIN_DIM)) begin
            w_eff = CMP_BITS'(MIN_DIM);
        end else if (w_eff > CMP_BITS'(MAX_WIDTH)) begin
            w_eff = CMP_BITS'(MAX_WIDTH);
        end
        w_last = w_eff - 1'b1;
        col_ext = CMP_BITS'(col_reg);
        last_col = (col_ext >= w_last);

        h_eff = (frame_height_reg < DIM_BITS'(MIN_DIM)) ? DIM_BITS'(MIN_DIM)
                                                      : frame_height_reg;
        h_last = h_eff - 1'b1;
        last_row = (row_reg >= h_last);

        flags.emit = (row_reg >= DIM_BITS'(2)) && (col_ext >= CMP_BITS'(2));
        flags.last_col = last_col;
        flags.last_row = last_row;

        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end

        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            unique case (nms_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg <= cfg_wr_data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_mag_reg <= s_magnitude;
            s1_dir_reg <= s_direction;
            s1_col_reg <= col_reg;
            s1_flags_reg <= flags;
        end
    end

    // word layout: {middle direction, middle magnitude, upper magnitude}
    assign wr_data = {s1_dir_reg, s1_mag_reg, rd_data[2*MAG_BITS-1:MAG_BITS]};

    nms_ram #(
        .WIDTH(RAM_W),
        .DEPTH(MAX_WIDTH)
    ) u_row_ram (
        .aclk   (aclk),
        .wr_en  (advance),
        .wr_addr(s1_col_reg),
        .wr_data(wr_data),
        .rd_en  (accept),
        .rd_addr(col_reg),
        .rd_data(rd_data)
    );

    assign q_push = advance;
    assign q_up_mag = rd_data[MAG_BITS-1:0];
    assign q_mid_mag = rd_data[2*MAG_BITS-1:MAG_BITS];
    assign q_mid_dir = rd_data[RAM_W-1:2*MAG_BITS];
    assign q_mag = s1_mag_reg;
    assign q_flags = s1_flags_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && accept) |-> (s1_col_reg != col_reg))
        else $error("row store read and write collide");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !advance) |-> !s1_valid_reg)
        else $error("stage overwritten while held");
`endif

endmodule

### sv/nms_back.sv
module nms_back
    import nms_pkg::*;
#(
    parameter int MAG_BITS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_empty,
    output logic                q_pop,
    input  logic [MAG_BITS-1:0] q_up_mag,
    input  logic [MAG_BITS-1:0] q_mid_mag,
    input  logic [1:0]          q_mid_dir,
    input  logic [MAG_BITS-1:0] q_mag,
    input  nms_flags_t          q_flags,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [MAG_BITS-1:0] m_edge_value,
    output logic                m_end_of_row,
    output logic                m_end_of_frame
);

    logic [MAG_BITS-1:0] c1_top_reg, c1_mid_reg, c1_bot_reg;
    logic [MAG_BITS-1:0] c2_top_reg, c2_mid_reg, c2_bot_reg;
    logic [1:0]          dir2_reg;

    logic                out_valid_reg, out_valid_next;
    logic [MAG_BITS-1:0] out_value_reg;
    logic                out_eor_reg, out_eof_reg;

    logic                slot_free;
    logic [MAG_BITS-1:0] center, n1, n2, value;

    assign slot_free = !out_valid_reg || m_ready;
    assign q_pop = !q_empty && (!q_flags.emit || slot_free);

    always_comb begin
        center = c2_mid_reg;
        unique case (nms_dir_t'(dir2_reg))
            DIR_0: begin
                n1 = q_mid_mag;
                n2 = c1_mid_reg;
            end
            DIR_45: begin
                n1 = q_up_mag;
                n2 = c1_bot_reg;
            end
            DIR_90: begin
                n1 = c2_top_reg;
                n2 = c2_bot_reg;
            end
            DIR_135: begin
                n1 = c1_top_reg;
                n2 = q_mag;
            end
            default: begin
                n1 = c1_top_reg;
                n2 = q_mag;
            end
        endcase
        value = (center < n1 || center < n2) ? '0 : center;

        out_valid_next = out_valid_reg;
        if (q_pop && q_flags.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            c1_top_reg <= '0;
            c1_mid_reg <= '0;
            c1_bot_reg <= '0;
            c2_top_reg <= '0;
            c2_mid_reg <= '0;
            c2_bot_reg <= '0;
            dir2_reg <= DIR_0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                c1_top_reg <= c2_top_reg;
                c1_mid_reg <= c2_mid_reg;
                c1_bot_reg <= c2_bot_reg;
                c2_top_reg <= q_up_mag;
                c2_mid_reg <= q_mid_mag;
                c2_bot_reg <= q_mag;
                dir2_reg <= q_mid_dir;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_flags.emit) begin
            out_value_reg <= value;
            out_eor_reg <= q_flags.last_col;
            out_eof_reg <= q_flags.last_col && q_flags.last_row;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_edge_value = out_value_reg;
    assign m_end_of_row = out_eor_reg;
    assign m_end_of_frame = out_eof_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_flags.emit) |=> out_valid_reg)
        else $error("emitted beat lost");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(q_pop && q_flags.emit))
        else $error("result overwritten while held");
`endif

endmodule

### sv/canny_non_max_suppression.sv
// Canny non-maximum suppression over a 3x3 window. Pixels (magnitude and
// 2-bit direction) arrive in raster order; the input at row r, column c with
// r >= 2 and c >= 2 yields one beat for center (r-1, c-1), so the output frame
// is (width-2) x (height-2) with end-of-row and end-of-frame marks. A pixel
// smaller than either neighbor along its direction comes out as zero. The
// block takes one pixel per clock unless the queue is full; a pixel's beat
// passes the front stage register, the queue and the output register before
// it is on m_valid. The rate is set by the single row RAM, read when a pixel
// is accepted and written back with the shifted row pair when that pixel
// leaves the front stage; a four-beat queue lets the row-store front and the
// window back stall apart. frame_width and frame_height are clamped to at
// least 3 (width at most MAX_WIDTH); the user must write them only while the
// block is idle, which the block does not enforce. The row RAM needs no
// clearing: stale words are read only in rows 0 and 1, which emit nothing.
module canny_non_max_suppression
    import nms_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAG_BITS = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [REG_IDX_BITS-1:0] cfg_index,
    input  logic [DIM_BITS-1:0]     cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [MAG_BITS-1:0]     s_magnitude,
    input  logic [1:0]              s_direction,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [MAG_BITS-1:0]     m_edge_value,
    output logic                    m_end_of_row,
    output logic                    m_end_of_frame
);

    localparam int FLAG_W = $bits(nms_flags_t);
    localparam int Q_W = 3 * MAG_BITS + 2 + FLAG_W;

    logic                q_push, q_full, q_pop, q_empty;
    logic [MAG_BITS-1:0] f_up_mag, f_mid_mag, f_mag;
    logic [1:0]          f_mid_dir;
    nms_flags_t          f_flags;
    logic [MAG_BITS-1:0] b_up_mag, b_mid_mag, b_mag;
    logic [1:0]          b_mid_dir;
    nms_flags_t          b_flags;
    logic [Q_W-1:0]      q_in, q_out;

    nms_front #(
        .MAX_WIDTH(MAX_WIDTH),
        .MAG_BITS (MAG_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_magnitude(s_magnitude),
        .s_direction(s_direction),
        .q_push     (q_push),
        .q_full     (q_full),
        .q_up_mag   (f_up_mag),
        .q_mid_mag  (f_mid_mag),
        .q_mid_dir  (f_mid_dir),
        .q_mag      (f_mag),
        .q_flags    (f_flags)
    );

    assign q_in = {f_flags, f_mid_dir, f_up_mag, f_mid_mag, f_mag};

    nms_queue #(
        .WIDTH(Q_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_in),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (q_out),
        .empty    (q_empty)
    );

    assign {b_flags, b_mid_dir, b_up_mag, b_mid_mag, b_mag} = q_out;

    nms_back #(
        .MAG_BITS(MAG_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_up_mag      (b_up_mag),
        .q_mid_mag     (b_mid_mag),
        .q_mid_dir     (b_mid_dir),
        .q_mag         (b_mag),
        .q_flags       (b_flags),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_edge_value  (m_edge_value),
        .m_end_of_row  (m_end_of_row),
        .m_end_of_frame(m_end_of_frame)
    );

endmodule
